/* hdl/orf_pkg.sv */
`default_nettype none
package orf_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
	localparam int HDR_LEN = 4;
	localparam int FIFO_AW = 2;

	// option parser position within the field
	typedef enum logic [2:0] {
		PH_TYPE = 3'b001,
		PH_LEN  = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic        reject_needed;
		logic [15:0] reject_length;
		logic        end_of_run;
	} result_t;

	// up to two results per input word, first slot filled first
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage
`default_nettype wire

/* hdl/orf_parse.sv */
`default_nettype none
module orf_parse
	import orf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [SLOT_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]            cfg_data,
	input  wire logic                  step,
	input  wire logic [7:0]            byte_s1,
	input  wire logic                  last_s1,
	output push_t                      push
);

	logic [7:0]  supported_q [NUM_SLOTS];
	phase_t      phase_q;
	logic [7:0]  left_q;
	logic        opt_rej_q;
	logic        any_rej_q;
	logic [15:0] cnt_q;

	phase_t      phase_d;
	logic [7:0]  left_d;
	logic        opt_rej_d;
	logic        any_rej_d;
	logic        match;
	logic        emit;
	logic [7:0]  len_eff;
	logic [15:0] cnt_d;
	logic [16:0] total;
	result_t     byte_res;
	result_t     sum_res;

	always_comb begin
		match = 1'b0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (supported_q[k] != 8'd0 && supported_q[k] == byte_s1) begin
				match = 1'b1;
			end
		end
	end

	// lengths under two mean an option with no data
	assign len_eff = (byte_s1 < 8'd2) ? 8'd2 : byte_s1;

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		opt_rej_d = opt_rej_q;
		any_rej_d = any_rej_q;
		case (phase_q)
			PH_LEN: begin
				left_d  = len_eff - 8'd2;
				phase_d = (left_d != 8'd0) ? PH_DATA : PH_TYPE;
			end
			PH_DATA: begin
				left_d  = left_q - 8'd1;
				phase_d = (left_d == 8'd0) ? PH_TYPE : PH_DATA;
			end
			default: begin
				opt_rej_d = !match;
				any_rej_d = any_rej_q | !match;
				phase_d   = PH_LEN;
			end
		endcase
		emit  = opt_rej_d;
		cnt_d = (emit && cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
	end

	assign total = {1'b0, cnt_d} + 17'(HDR_LEN);

	always_comb begin
		byte_res.kind          = 1'b0;
		byte_res.data_byte     = byte_s1;
		byte_res.reject_needed = 1'b0;
		byte_res.reject_length = 16'd0;
		byte_res.end_of_run    = !last_s1;
		sum_res.kind           = 1'b1;
		sum_res.data_byte      = 8'd0;
		sum_res.reject_needed  = any_rej_d;
		sum_res.reject_length  = total[16] ? 16'hFFFF : total[15:0];
		sum_res.end_of_run     = 1'b1;
		push.v0 = step && (emit || last_s1);
		push.v1 = step && emit && last_s1;
		push.r0 = emit ? byte_res : sum_res;
		push.r1 = sum_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				supported_q[k] <= 8'd0;
			end
		end else if (cfg_wr_en) begin
			supported_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE;
			left_q    <= 8'd0;
			opt_rej_q <= 1'b0;
			any_rej_q <= 1'b0;
			cnt_q     <= 16'd0;
		end else if (step) begin
			if (last_s1) begin
				// field ends, even in the middle of an option
				phase_q   <= PH_TYPE;
				left_q    <= 8'd0;
				opt_rej_q <= 1'b0;
				any_rej_q <= 1'b0;
				cnt_q     <= 16'd0;
			end else begin
				phase_q   <= phase_d;
				left_q    <= left_d;
				opt_rej_q <= opt_rej_d;
				any_rej_q <= any_rej_d;
				cnt_q     <= cnt_d;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> phase_q == PH_TYPE && cnt_q == 16'd0 && !any_rej_q)
		else $error("field state not cleared after last word");

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != 8'd0)
		else $error("data phase with no bytes left");

	a_rej_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 16'd0 |-> any_rej_q)
		else $error("bytes copied with no rejected option");

endmodule
`default_nettype wire

/* hdl/orf_result_fifo.sv */
`default_nettype none
module orf_result_fifo
	import orf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room2,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    head
);

	localparam int DEPTH = 1 << FIFO_AW;

	result_t            mem [DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;
	logic [FIFO_AW:0]   n_push;
	logic [FIFO_AW:0]   free;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign head      = mem[rp_q];
	assign n_push    = (FIFO_AW+1)'(push.v0) + (FIFO_AW+1)'(push.v1);
	assign free      = (FIFO_AW+1)'(DEPTH) - count_q + (FIFO_AW+1)'(pop);
	// two free slots so a word that yields a byte and a summary always fits
	assign room2     = free >= (FIFO_AW+1)'(2);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[wp_q] <= push.r0;
		end
		if (push.v1) begin
			mem[wp_q + FIFO_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + n_push[FIFO_AW-1:0];
			rp_q    <= rp_q + FIFO_AW'(pop);
			count_q <= count_q + n_push - (FIFO_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(DEPTH))
		else $error("result queue overflow");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && push.r1.kind && !push.r0.kind)
		else $error("second result without a copied byte first");

endmodule
`default_nettype wire

/* hdl/ppp_option_reject_filter.sv */
// channel | handshake             | payload
// in      | in_valid / in_ready   | opt_byte, last_byte
// out     | out_valid / out_ready | kind, data_byte, reject_needed, reject_length, end_of_run
// cfg     | cfg_wr_en             | cfg_index, cfg_data
//
// one word per cycle in while the queue has room; accepted words are registered, then queued
// a last word that also copies a byte yields two results, which the four-entry result
// queue drains one per cycle while out_ready is high; it sets the rate after such a word
// input is held back while the queue lacks two free slots
// reset clears parser state, queue pointers and all supported-type slots to empty
`default_nettype none
module ppp_option_reject_filter
	import orf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [SLOT_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]            cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            opt_byte,
	input  wire logic                  last_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       kind,
	output logic [7:0]                 data_byte,
	output logic                       reject_needed,
	output logic [15:0]                reject_length,
	output logic                       end_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room2;
	logic       step;
	push_t      push;
	result_t    head;

	assign step     = valid_s1 && room2;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= opt_byte;
			last_s1 <= last_byte;
		end
	end

	orf_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1),
		.push      (push)
	);

	orf_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind          = head.kind;
	assign data_byte     = head.data_byte;
	assign reject_needed = head.reject_needed;
	assign reject_length = head.reject_length;
	assign end_of_run    = head.end_of_run;

endmodule
`default_nettype wire
